// ----- rtl/chkv_pkg.sv -----
`default_nettype none
package chkv_pkg;
  localparam int BucketsDefault = 256;
  localparam int EntriesDefault = 1024;
  localparam int CountW = 11;

  localparam logic [63:0] HashAdd = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HashMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HashMul2 = 64'h94d049bb133111eb;

  localparam logic [1:0] ActSet = 2'd0;
  localparam logic [1:0] ActGet = 2'd1;
  localparam logic [1:0] ActRemove = 2'd2;
  localparam logic [1:0] ActNone = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic signed [63:0] key;
    logic [63:0] value;
  } chkv_in_t;

  typedef struct packed {
    logic found;
    logic [63:0] value_out;
    logic status;
    logic [CountW-1:0] count;
  } chkv_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HEAD, S_HEADW, S_KEY, S_KEYW, S_HIT, S_UNLINK,
    S_FREEW, S_ALLOC, S_PUSH, S_DONE, S_CLEAR
  } chkv_state_t;

  typedef struct packed {
    logic hash_go;
    logic cur_from_head;
    logic cur_from_link;
    logic read_head;
    logic read_entry;
    logic read_freelink;
    logic wr_value;
    logic wr_unlink;
    logic wr_push;
    logic free_push;
    logic alloc_free;
    logic alloc_fresh;
    logic clear_step;
    logic respond;
    logic set_found;
    logic set_full;
    logic get_value;
  } chkv_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic cur_nil;
    logic key_match;
    logic step_limit;
    logic free_avail;
    logic fresh_avail;
    logic clear_done;
  } chkv_stat_t;
endpackage
`default_nettype wire

// ----- rtl/chained_hash_key_value_store_top.sv -----
`default_nettype none
// Hash map of 64-bit keys and values with separate chaining. After reset the
// bucket table is cleared one bucket a cycle, with busy high. An item whose
// bucket chain is empty passes through hashing (six 32x32 partial products),
// the bucket head read, the chain test and the response. Each chain entry
// visited passes through S_KEY, S_KEYW and S_HIT, since the entry memories'
// single registered read port sets the walk speed; a set that takes a
// never-used entry adds S_PUSH, one that reuses a freed entry adds S_FREEW,
// S_ALLOC and S_PUSH, and a remove that hits adds S_UNLINK. Each result is
// shown for one cycle with done high; the receiver cannot stall it.
module chained_hash_key_value_store_top import chkv_pkg::*; #(
  parameter int Buckets = BucketsDefault,
  parameter int Entries = EntriesDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire chkv_in_t in_item,
  output chkv_out_t result,
  output logic done
);
  chkv_cmd_t cmd;
  chkv_stat_t stat;

  chkv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(in_item.action),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  chkv_dp #(.Buckets(Buckets), .Entries(Entries)) u_dp (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cmd(cmd), .stat(stat), .result(result), .strobe(done)
  );
endmodule
`default_nettype wire

// ----- rtl/chkv_ram.sv -----
`default_nettype none
module chkv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/chkv_hash.sv -----
`default_nettype none
module chkv_hash import chkv_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic go,
  input wire logic [63:0] key,
  output logic done,
  output logic [63:0] hash
);
  // multiplies split into 32x32 partial products, one per cycle
  logic [2:0] step;
  logic [63:0] z, a;
  logic [63:0] acc;
  logic [63:0] pp;
  logic [63:0] mul;
  logic [1:0] part;

  assign z = key + HashAdd;

  always_comb begin
    mul = (step < 3'd4) ? HashMul1 : HashMul2;
    unique case (part)
      2'd0: pp = 64'(a[31:0]) * 64'(mul[31:0]);
      2'd1: pp = {a[31:0] * mul[63:32], 32'd0};
      default: pp = {a[63:32] * mul[31:0], 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
      part <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        a <= z ^ (z >> 30);
        acc <= 64'd0;
        part <= 2'd0;
        step <= 3'd1;
      end else if (step != 3'd0) begin
        acc <= acc + pp;
        if (part == 2'd2) begin
          part <= 2'd0;
          if (step < 3'd4) begin
            a <= (acc + pp) ^ ((acc + pp) >> 27);
            acc <= 64'd0;
            step <= 3'd4;
          end else begin
            hash <= (acc + pp) ^ ((acc + pp) >> 31);
            step <= 3'd0;
            done <= 1'b1;
          end
        end else begin
          part <= part + 2'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/chkv_ctrl.sv -----
`default_nettype none
module chkv_ctrl import chkv_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [1:0] action,
  input wire chkv_stat_t stat,
  output chkv_cmd_t cmd,
  output logic busy
);
  chkv_state_t state, state_next;
  logic [1:0] act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      act <= ActSet;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) act <= action;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (action == ActNone) state_next = S_DONE;
          else begin
            cmd.hash_go = 1'b1;
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.read_head = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: state_next = S_HEADW;
      S_HEADW: begin
        cmd.cur_from_head = 1'b1;
        state_next = S_KEY;
      end
      S_KEY: begin
        if (stat.cur_nil || stat.step_limit) begin
          if (act == ActSet) begin
            if (stat.free_avail) begin
              cmd.read_freelink = 1'b1;
              state_next = S_FREEW;
            end else if (stat.fresh_avail) begin
              cmd.alloc_fresh = 1'b1;
              state_next = S_PUSH;
            end else begin
              cmd.set_full = 1'b1;
              state_next = S_DONE;
            end
          end else state_next = S_DONE;
        end else begin
          cmd.read_entry = 1'b1;
          state_next = S_KEYW;
        end
      end
      S_KEYW: state_next = S_HIT;
      S_HIT: begin
        if (stat.key_match) begin
          cmd.set_found = 1'b1;
          unique case (act)
            ActSet: begin
              cmd.wr_value = 1'b1;
              state_next = S_DONE;
            end
            ActGet: begin
              cmd.get_value = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              cmd.wr_unlink = 1'b1;
              state_next = S_UNLINK;
            end
          endcase
        end else begin
          cmd.cur_from_link = 1'b1;
          state_next = S_KEY;
        end
      end
      S_UNLINK: begin
        cmd.free_push = 1'b1;
        state_next = S_DONE;
      end
      S_FREEW: begin
        // hold the free head address so the link read stays valid
        cmd.read_freelink = 1'b1;
        state_next = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc_free = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.wr_push = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/chkv_dp.sv -----
`default_nettype none
module chkv_dp import chkv_pkg::*; #(
  parameter int Buckets = BucketsDefault,
  parameter int Entries = EntriesDefault
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire chkv_in_t in_item,
  input wire chkv_cmd_t cmd,
  output chkv_stat_t stat,
  output chkv_out_t result,
  output logic strobe
);
  localparam int BW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int EW = $clog2(Entries);
  localparam int PW = EW + 1;
  localparam logic [PW-1:0] Nil = PW'(Entries);

  chkv_in_t item;
  logic [63:0] hash;
  logic [BW-1:0] bucket;
  logic [PW-1:0] cur, prev, hit_link, free_head, fresh, alloc_e;
  logic [PW-1:0] walk_steps;
  logic [CountW-1:0] entry_count;
  logic found, status;
  logic [63:0] vout;
  logic [BW-1:0] clr;
  logic clearing_last;

  // bucket head memory
  logic hd_we;
  logic [BW-1:0] hd_wa;
  logic [PW-1:0] hd_wd, hd_rd;
  // entry memories
  logic k_we, v_we, l_we;
  logic [EW-1:0] k_wa, v_wa, l_wa, e_ra, l_ra;
  logic [63:0] k_wd, v_wd, k_rd, v_rd;
  logic [PW-1:0] l_wd, l_rd;

  // the hash starts at the accepting edge, so it takes the key from the port
  chkv_hash u_hash (
    .clk(clk), .rst(rst), .go(cmd.hash_go), .key(in_item.key),
    .done(stat.hash_done), .hash(hash)
  );

  // bucket count is a power of two
  assign bucket = hash[BW-1:0];

  chkv_ram #(.Width(PW), .Depth(Buckets)) u_head (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(bucket), .rdata(hd_rd)
  );
  chkv_ram #(.Width(64), .Depth(Entries)) u_key (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(e_ra), .rdata(k_rd)
  );
  chkv_ram #(.Width(64), .Depth(Entries)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(e_ra), .rdata(v_rd)
  );
  chkv_ram #(.Width(PW), .Depth(Entries)) u_link (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
  );

  assign e_ra = cur[EW-1:0];
  assign l_ra = cmd.read_freelink ? free_head[EW-1:0] : cur[EW-1:0];
  assign clearing_last = (clr == BW'(Buckets - 1));

  always_comb begin
    hd_we = 1'b0; hd_wa = bucket; hd_wd = Nil;
    k_we = 1'b0; k_wa = alloc_e[EW-1:0]; k_wd = item.key;
    v_we = 1'b0; v_wa = alloc_e[EW-1:0]; v_wd = item.value;
    l_we = 1'b0; l_wa = alloc_e[EW-1:0]; l_wd = hd_rd;
    if (cmd.clear_step) begin
      hd_we = 1'b1; hd_wa = clr; hd_wd = Nil;
    end
    if (cmd.wr_value) begin
      v_we = 1'b1; v_wa = cur[EW-1:0];
    end
    if (cmd.wr_unlink) begin
      // bypass prev link or head
      if (prev == Nil) begin
        hd_we = 1'b1; hd_wd = l_rd;
      end else begin
        l_we = 1'b1; l_wa = prev[EW-1:0]; l_wd = l_rd;
      end
    end
    if (cmd.free_push) begin
      l_we = 1'b1; l_wa = cur[EW-1:0]; l_wd = free_head;
    end
    if (cmd.wr_push) begin
      k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; l_wd = hd_rd;
      hd_we = 1'b1; hd_wd = alloc_e;
    end
  end

  assign stat.cur_nil = (cur >= Nil);
  assign stat.key_match = (k_rd == item.key);
  assign stat.step_limit = (walk_steps >= PW'(Entries));
  assign stat.free_avail = (free_head < Nil);
  assign stat.fresh_avail = (fresh < PW'(Entries));
  assign stat.clear_done = clearing_last;

  always_ff @(posedge clk) begin
    if (start && !busy) item <= in_item;
    if (cmd.cur_from_head) begin
      cur <= hd_rd; prev <= Nil; walk_steps <= '0;
    end
    if (cmd.cur_from_link) begin
      prev <= cur; cur <= l_rd; walk_steps <= walk_steps + 1'b1;
    end
    if (cmd.get_value) vout <= v_rd;
    if (cmd.alloc_fresh) alloc_e <= fresh;
    if (cmd.alloc_free) alloc_e <= free_head;
    if (rst) begin
      clr <= '0;
      free_head <= Nil;
      fresh <= '0;
      entry_count <= '0;
      strobe <= 1'b0;
      found <= 1'b0; status <= 1'b0; vout <= '0;
    end else begin
      strobe <= cmd.respond;
      if (start && !busy) begin
        found <= 1'b0; status <= 1'b0; vout <= '0;
      end
      if (cmd.clear_step) clr <= clr + 1'b1;
      if (cmd.set_found) found <= 1'b1;
      if (cmd.set_full) status <= 1'b1;
      if (cmd.free_push) begin
        free_head <= cur;
        if (entry_count != '0) entry_count <= entry_count - 1'b1;
      end
      if (cmd.alloc_fresh) fresh <= fresh + 1'b1;
      if (cmd.alloc_free) free_head <= l_rd;
      if (cmd.wr_push) entry_count <= entry_count + 1'b1;
    end
  end

  assign result.found = found;
  assign result.value_out = vout;
  assign result.status = status;
  assign result.count = entry_count;
endmodule
`default_nettype wire

// ----- verif/chkv_checker.sv -----
`timescale 1ns / 1ps
module chkv_checker import chkv_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire chkv_in_t in_item,
  input wire chkv_out_t result,
  input wire logic done,
  output int fail_count,
  output int pending
);
  localparam int NBkt = BucketsDefault;
  localparam int NSlot = EntriesDefault;
  localparam int Nil = EntriesDefault;

  int bkt_first[NBkt];
  logic [63:0] slot_key[NSlot];
  logic [63:0] slot_val[NSlot];
  int slot_next[NSlot];
  int free_top;
  int next_unused;
  int stored;
  chkv_out_t answers[$];
  int shown;

  function automatic int bucket_for(logic [63:0] k);
    logic [63:0] z;
    z = k + HashAdd;
    z = (z ^ (z >> 30)) * HashMul1;
    z = (z ^ (z >> 27)) * HashMul2;
    z = z ^ (z >> 31);
    return int'(z % NBkt);
  endfunction

  function automatic chkv_out_t apply_action(chkv_in_t it);
    chkv_out_t r;
    int b, cur, prev, hit, steps, e;
    r = '0;
    b = bucket_for(it.key);
    if (it.action == ActSet || it.action == ActGet || it.action == ActRemove) begin
      cur = bkt_first[b];
      prev = Nil;
      hit = Nil;
      steps = 0;
      while (cur < Nil && steps < NSlot && hit == Nil) begin
        if (slot_key[cur] == it.key) hit = cur;
        else begin
          prev = cur;
          cur = slot_next[cur];
          steps++;
        end
      end
      if (hit < Nil) begin
        r.found = 1'b1;
        case (it.action)
          ActSet: slot_val[hit] = it.value;
          ActGet: r.value_out = slot_val[hit];
          default: begin
            if (prev < Nil) slot_next[prev] = slot_next[hit];
            else bkt_first[b] = slot_next[hit];
            slot_next[hit] = free_top;
            free_top = hit;
            if (stored > 0) stored--;
          end
        endcase
      end else if (it.action == ActSet) begin
        e = Nil;
        if (free_top < Nil) begin
          e = free_top;
          free_top = slot_next[e];
        end else if (next_unused < NSlot) begin
          e = next_unused;
          next_unused++;
        end
        if (e < Nil) begin
          slot_key[e] = it.key;
          slot_val[e] = it.value;
          slot_next[e] = bkt_first[b];
          bkt_first[b] = e;
          stored++;
        end else r.status = 1'b1;
      end
    end
    r.count = stored[CountW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    chkv_out_t exp_r;
    if (rst) begin
      foreach (bkt_first[i]) bkt_first[i] = Nil;
      free_top = Nil;
      next_unused = 0;
      stored = 0;
      answers.delete();
      fail_count <= 0;
      shown = 0;
    end else begin
      if (done) begin
        if (answers.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10) $display("unexpected result %p", result);
          shown++;
        end else begin
          exp_r = answers.pop_front();
          if (result.found !== exp_r.found || result.value_out !== exp_r.value_out ||
              result.status !== exp_r.status || result.count !== exp_r.count) begin
            fail_count <= fail_count + 1;
            if (shown < 10)
              $display("mismatch: expected found %0d value %h status %0d count %0d, got found %0d value %h status %0d count %0d",
                       exp_r.found, exp_r.value_out, exp_r.status, exp_r.count,
                       result.found, result.value_out, result.status, result.count);
            shown++;
          end
        end
      end
      if (start && !busy) answers.push_back(apply_action(in_item));
    end
    pending <= answers.size();
  end
endmodule

// ----- verif/tb_chained_hash_key_value_store_top.sv -----
`timescale 1ns / 1ps
module tb_chained_hash_key_value_store_top;
  import chkv_pkg::*;

  localparam int StallLimit = 30000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  chkv_in_t in_item = '0;
  chkv_out_t result;
  int fail_count, pending;
  int idle_cycles = 0;
  logic [63:0] known_keys[$];

  always #10 clk = ~clk;

  chained_hash_key_value_store_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .result(result), .done(done)
  );

  chkv_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result(result), .done(done), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at a rising edge; returns at the edge that takes the item
  task automatic issue(logic [1:0] act, logic [63:0] k, logic [63:0] v);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{action: act, key: k, value: v};
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key(int fresh_pct);
    logic [63:0] k;
    if (known_keys.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
      k = rand64();
      known_keys.push_back(k);
    end else k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    return k;
  endfunction

  task automatic mixed(int n, int fresh_pct, int rm_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) issue(ActNone, rand64(), rand64());
      else if (r < 5 + rm_pct) issue(ActRemove, pick_key(fresh_pct / 2), rand64());
      else if (r < 40 + rm_pct) issue(ActGet, pick_key(fresh_pct / 2), rand64());
      else issue(ActSet, pick_key(fresh_pct), rand64());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map, key extremes, overwrite, remove, unused code
    issue(ActGet, 64'h8000_0000_0000_0000, '1);
    issue(ActRemove, 64'h7fff_ffff_ffff_ffff, '0);
    issue(ActNone, '1, '1);
    issue(ActSet, 64'h8000_0000_0000_0000, '1);
    issue(ActSet, 64'h7fff_ffff_ffff_ffff, '0);
    issue(ActSet, '0, 64'h5555_aaaa_5555_aaaa);
    issue(ActSet, '1, 64'haaaa_5555_aaaa_5555);
    issue(ActGet, 64'h8000_0000_0000_0000, '0);
    issue(ActGet, 64'h7fff_ffff_ffff_ffff, '0);
    issue(ActGet, '0, '0);
    issue(ActGet, '1, '0);
    issue(ActSet, '0, '1);
    issue(ActGet, '0, '0);
    issue(ActNone, '0, '0);
    issue(ActRemove, '0, '0);
    issue(ActGet, '0, '0);
    issue(ActRemove, '0, '0);
    issue(ActSet, 64'h1, 64'h1);
    issue(ActRemove, '1, '0);
    issue(ActRemove, 64'h8000_0000_0000_0000, '0);
    issue(ActGet, 64'h1, '0);
    drain();

    mixed(300, 30, 15);
    drain();
    // fill the pool past capacity
    for (int i = 0; i < 1150; i++) begin
      if ($urandom_range(0, 9) < 9) issue(ActSet, pick_key(100), rand64());
      else issue(ActGet, pick_key(0), rand64());
    end
    // free entries come back through the free list
    mixed(250, 10, 45);
    mixed(100, 40, 10);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/chkv_pkg.sv
rtl/chkv_ram.sv
rtl/chkv_hash.sv
rtl/chkv_ctrl.sv
rtl/chkv_dp.sv
rtl/chained_hash_key_value_store_top.sv
verif/chkv_checker.sv
verif/tb_chained_hash_key_value_store_top.sv
